// ===== rtl/ctbd_pkg.sv =====
// Package for the BC1/BC3 texture block decoder.
// Holds the queue depth, format codes and the decoded-block entry type.
// No dependencies.
package ctbd_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic FMT_BC1 = 1'b0;
  localparam logic FMT_BC3 = 1'b1;

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic [31:0] argb_t;
  typedef logic [7:0]  alpha_t;

  typedef struct packed {
    logic            bc3;
    argb_t [3:0]     cpal;
    alpha_t [7:0]    apal;
    logic [47:0]     aidx;
    logic [31:0]     cidx;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/ctbd_front.sv =====
// Front end: format register, input stage and palette construction.
// Depends on ctbd_pkg; pushes one decoded-block entry into the queue.
module ctbd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_alpha_half,
  input  logic [63:0]       in_color_half,
  input  ctbd_pkg::q_stat_t q_stat,
  output logic              push,
  output ctbd_pkg::entry_t  push_entry
);

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  logic        fmt_r;
  logic        stg_valid_r, stg_valid_nxt;
  logic        stg_bc3_r;
  logic [63:0] stg_alpha_r;
  logic [63:0] stg_color_r;
  logic        accept;

  assign in_stall = stg_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = stg_valid_r && !q_stat.full;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (push) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= ctbd_pkg::FMT_BC1;
      stg_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_bc3_r   <= fmt_r;
      stg_alpha_r <= in_alpha_half;
      stg_color_r <= in_color_half;
    end
  end

  logic [15:0] e0, e1;
  logic [7:0]  r0, g0, b0, r1, g1, b1;
  logic        four;
  logic [7:0]  a0, a1;

  assign e0 = stg_color_r[15:0];
  assign e1 = stg_color_r[31:16];
  assign r0 = {e0[15:11], 3'b000};
  assign g0 = {e0[10:5], 2'b00};
  assign b0 = {e0[4:0], 3'b000};
  assign r1 = {e1[15:11], 3'b000};
  assign g1 = {e1[10:5], 2'b00};
  assign b1 = {e1[4:0], 3'b000};
  assign four = (stg_bc3_r == ctbd_pkg::FMT_BC3) || (e0 > e1);
  assign a0 = stg_alpha_r[7:0];
  assign a1 = stg_alpha_r[15:8];

  function automatic logic [7:0] third(input logic [7:0] p, input logic [7:0] q);
    return div3({1'b0, p, 1'b0} + {2'b00, q} + 10'd1);
  endfunction

  function automatic logic [7:0] half(input logic [7:0] p, input logic [7:0] q);
    logic [8:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[8:1];
  endfunction

  always_comb begin
    logic [7:0] opq;
    push_entry      = '0;
    push_entry.bc3  = stg_bc3_r;
    push_entry.aidx = stg_alpha_r[63:16];
    push_entry.cidx = stg_color_r[63:32];
    opq = (stg_bc3_r == ctbd_pkg::FMT_BC3) ? 8'h00 : 8'hff;
    push_entry.cpal[0] = {opq, r0, g0, b0};
    push_entry.cpal[1] = {opq, r1, g1, b1};
    if (four) begin
      push_entry.cpal[2] = {opq, third(r0, r1), third(g0, g1), third(b0, b1)};
      push_entry.cpal[3] = {opq, third(r1, r0), third(g1, g0), third(b1, b0)};
    end else begin
      push_entry.cpal[2] = {8'hff, half(r0, r1), half(g0, g1), half(b0, b1)};
      push_entry.cpal[3] = 32'd0;
    end
    push_entry.apal[0] = a0;
    push_entry.apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) begin
        push_entry.apal[k] = div7(4'(8 - k) * {3'd0, a0} + 4'(k - 1) * {3'd0, a1} + 11'd3);
      end
    end else begin
      for (int k = 2; k < 6; k++) begin
        push_entry.apal[k] = div5(3'(6 - k) * {3'd0, a0} + 3'(k - 1) * {3'd0, a1} + 11'd2);
      end
      push_entry.apal[6] = 8'd0;
      push_entry.apal[7] = 8'd255;
    end
  end

endmodule

// ===== rtl/ctbd_fifo.sv =====
// Short queue of decoded-block entries between the front and back ends.
// Depends on ctbd_pkg for the entry type and depth.
module ctbd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ctbd_pkg::entry_t  push_entry,
  input  logic              pop,
  output ctbd_pkg::q_stat_t q_stat,
  output ctbd_pkg::entry_t  head
);

  ctbd_pkg::entry_t mem [ctbd_pkg::QDEPTH];

  logic [ctbd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ctbd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ctbd_pkg::QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [ctbd_pkg::QPTR_W-1:0] bump(
    input logic [ctbd_pkg::QPTR_W-1:0] p
  );
    return (p == ctbd_pkg::QPTR_W'(ctbd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == ctbd_pkg::QCNT_W'(ctbd_pkg::QDEPTH));
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + ctbd_pkg::QCNT_W'(push) - ctbd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/ctbd_back.sv =====
// Back end: walks the four rows of the current block and registers each row.
// Depends on ctbd_pkg; pops entries from the queue.
module ctbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ctbd_pkg::q_stat_t q_stat,
  input  ctbd_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_row_index,
  output logic [31:0]       out_pixel_0,
  output logic [31:0]       out_pixel_1,
  output logic [31:0]       out_pixel_2,
  output logic [31:0]       out_pixel_3,
  output logic              out_last_row
);

  ctbd_pkg::entry_t cur_r;
  logic             cur_valid_r, cur_valid_nxt;
  logic [1:0]       row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_row_r;
  logic             out_last_r;
  ctbd_pkg::argb_t  out_px_r [4];
  ctbd_pkg::argb_t  row_px [4];
  logic             out_free, emit, done;
  logic [7:0]       cbits;
  logic [11:0]      abits;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && out_free;
  assign done     = emit && (row_r == ctbd_pkg::LAST_ROW);
  assign pop      = q_stat.valid && (!cur_valid_r || done);

  assign cbits = cur_r.cidx[row_r*8 +: 8];
  assign abits = cur_r.aidx[row_r*12 +: 12];

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      row_px[x] = cur_r.cpal[cbits[2*x +: 2]];
      if (cur_r.bc3 == ctbd_pkg::FMT_BC3) begin
        row_px[x][31:24] = cur_r.apal[abits[3*x +: 3]];
      end
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    row_nxt       = row_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      row_nxt       = 2'd0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      row_nxt = row_r + 2'd1;
    end
    out_valid_nxt = out_free ? cur_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      row_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (emit) begin
      out_row_r  <= row_r;
      out_last_r <= (row_r == ctbd_pkg::LAST_ROW);
      out_px_r   <= row_px;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_last_row  = out_last_r;
  assign out_pixel_0   = out_px_r[0];
  assign out_pixel_1   = out_px_r[1];
  assign out_pixel_2   = out_px_r[2];
  assign out_pixel_3   = out_px_r[3];

endmodule

// ===== rtl/compressed_texture_block_decoder_unit.sv =====
// BC1/BC3 block decoder: one 4x4 block in, four ARGB8888 rows out.
// Each block passes the input stage register, the two-entry queue, the back
// end's current-block register and the output register. The back end walks one
// row per cycle while out_stall is low; the two-entry queue absorbs stalls.
// Reset: synchronous, active low; empties all stages, format returns to BC1.
// Depends on ctbd_pkg, ctbd_front, ctbd_fifo and ctbd_back.
module compressed_texture_block_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_alpha_half,
  input  logic [63:0] in_color_half,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row_index,
  output logic [31:0] out_pixel_0,
  output logic [31:0] out_pixel_1,
  output logic [31:0] out_pixel_2,
  output logic [31:0] out_pixel_3,
  output logic        out_last_row
);

  ctbd_pkg::q_stat_t q_stat;
  ctbd_pkg::entry_t  push_entry;
  ctbd_pkg::entry_t  head;
  logic              push;
  logic              pop;

  ctbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_alpha_half(in_alpha_half),
    .in_color_half(in_color_half),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  ctbd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  ctbd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_pixel_0  (out_pixel_0),
    .out_pixel_1  (out_pixel_1),
    .out_pixel_2  (out_pixel_2),
    .out_pixel_3  (out_pixel_3),
    .out_last_row (out_last_row)
  );

  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_row) |=>
      (out_valid && out_row_index == $past(out_row_index) + 2'd1))
    else $error("row sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == ctbd_pkg::LAST_ROW)))
    else $error("last_row flag mismatch");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue overflow");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("outputs active after reset");

endmodule
